// File: rtl/rfc_pkg.sv
// rfc_pkg: shared widths, screen and buffer constants, status codes and
// the divider handshake types of the rectangle fill chunker.
// No dependencies.
package rfc_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int CHUNK_PIXELS  = 10 * 1024 / 2;
  localparam int MAX_RESULTS   = 64;

  localparam int COLOR_W  = 24;
  localparam int RGB565_W = 16;
  localparam int COORD_W  = 9;
  localparam int ROW_W    = 8;
  localparam int PIX_W    = 13;
  localparam int STAT_W   = 2;

  localparam int AREA_W    = 2 * COORD_W;
  localparam int NPIX_W    = $clog2(CHUNK_PIXELS + 1);
  localparam int K_W       = $clog2(MAX_RESULTS);
  localparam int DIV_CNT_W = $clog2(NPIX_W + 1);

  localparam logic [STAT_W-1:0] ST_CHUNK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [AREA_W-1:0]  area_t;
  typedef logic [NPIX_W-1:0]  npix_t;

  typedef struct packed {
    logic   start;
    npix_t  dividend;
    coord_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    npix_t  quot;
    coord_t remainder;
  } div_rsp_t;

  function automatic logic [RGB565_W-1:0] pack565(input logic [COLOR_W-1:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

// File: rtl/rfc_req_if.sv
// rfc_req_if: fill request channel, valid/ready with the request fields.
// Depends on rfc_pkg.
interface rfc_req_if;
  logic                          valid;
  logic                          ready;
  logic [rfc_pkg::COLOR_W-1:0]   color_rgb888;
  logic [rfc_pkg::COORD_W-1:0]   rect_x;
  logic [rfc_pkg::COORD_W-1:0]   rect_width;
  logic [rfc_pkg::COORD_W-1:0]   rect_y;
  logic [rfc_pkg::COORD_W-1:0]   rect_height;

  modport source (
    output valid, color_rgb888, rect_x, rect_width, rect_y, rect_height,
    input  ready
  );
  modport sink (
    input  valid, color_rgb888, rect_x, rect_width, rect_y, rect_height,
    output ready
  );
endinterface

// File: rtl/rfc_res_if.sv
// rfc_res_if: chunk result channel, valid/ready with window, count and colour.
// Depends on rfc_pkg.
interface rfc_res_if;
  logic                          valid;
  logic                          ready;
  logic [rfc_pkg::STAT_W-1:0]    status;
  logic [rfc_pkg::COORD_W-1:0]   win_x_first;
  logic [rfc_pkg::COORD_W-1:0]   win_x_end;
  logic [rfc_pkg::ROW_W-1:0]     win_y_first;
  logic [rfc_pkg::ROW_W-1:0]     win_y_end;
  logic [rfc_pkg::PIX_W-1:0]     pixel_count;
  logic [rfc_pkg::RGB565_W-1:0]  color_rgb565;
  logic                          last_chunk;

  modport source (
    output valid, status, win_x_first, win_x_end, win_y_first, win_y_end,
           pixel_count, color_rgb565, last_chunk,
    input  ready
  );
  modport sink (
    input  valid, status, win_x_first, win_x_end, win_y_first, win_y_end,
           pixel_count, color_rgb565, last_chunk,
    output ready
  );
endinterface

// File: rtl/rfc_div.sv
// rfc_div: radix-2 restoring divider, one quotient bit per cycle.
// Splits a chunk pixel count into whole rows and a column remainder.
// Depends on rfc_pkg.
module rfc_div (
  input  logic              clk,
  input  logic              rst,
  input  rfc_pkg::div_req_t req,
  output rfc_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [rfc_pkg::DIV_CNT_W-1:0]     cnt;
  rfc_pkg::npix_t                    dvd;
  rfc_pkg::coord_t                   prem;
  rfc_pkg::coord_t                   dvs;

  logic [rfc_pkg::COORD_W:0]         trial;
  logic [rfc_pkg::COORD_W:0]         diff;
  logic                              take;
  rfc_pkg::coord_t                   prem_next;

  always_comb begin
    trial     = {prem, dvd[rfc_pkg::NPIX_W-1]};
    diff      = trial - {1'b0, dvs};
    take      = trial >= {1'b0, dvs};
    prem_next = take ? diff[rfc_pkg::COORD_W-1:0] : trial[rfc_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rfc_pkg::DIV_CNT_W'(rfc_pkg::NPIX_W);
      end else if (busy) begin
        cnt <= cnt - rfc_pkg::DIV_CNT_W'(1);
        if (cnt == rfc_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      prem <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      dvd  <= {dvd[rfc_pkg::NPIX_W-2:0], take};
      prem <= prem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quot      = dvd;
  assign rsp.remainder = prem;

endmodule

// File: rtl/rect_fill_chunker_core.sv
// rect_fill_chunker_core: top level, request latch, chunk sequencer and
// output register. Depends on rfc_pkg, rfc_req_if, rfc_res_if and rfc_div.
//
//   channel  dir  payload
//   req      in   color_rgb888, rect_x, rect_width, rect_y, rect_height
//   res      out  status, win_x/y_first/end, pixel_count, color_rgb565, last_chunk
//
// one request at a time: req.ready is high only while the sequencer is idle
// setup passes through the check state; a chunk starting mid-line goes from
// plan straight to emit, a chunk starting on the left edge goes through div and
// waits for the bit-serial divider; rejected and empty requests give one beat
// a stalled res beat holds the next chunk in staging; rst is synchronous
module rect_fill_chunker_core (
  input  logic      clk,
  input  logic      rst,
  rfc_req_if.sink   req,
  rfc_res_if.source res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PLAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                       state;
  logic [2:0]                       state_next;

  logic [rfc_pkg::RGB565_W-1:0]     col;
  rfc_pkg::coord_t                  x0;
  rfc_pkg::coord_t                  w;
  rfc_pkg::coord_t                  y0;
  rfc_pkg::coord_t                  h;
  rfc_pkg::area_t                   rem;
  rfc_pkg::coord_t                  cx;
  rfc_pkg::coord_t                  ry;
  logic [rfc_pkg::K_W-1:0]          k;

  logic [rfc_pkg::STAT_W-1:0]       stg_status;
  rfc_pkg::coord_t                  stg_xf;
  rfc_pkg::coord_t                  stg_xe;
  logic [rfc_pkg::ROW_W-1:0]        stg_yf;
  logic [rfc_pkg::ROW_W-1:0]        stg_ye;
  rfc_pkg::npix_t                   stg_npix;
  logic                             stg_last;

  logic                             out_valid;
  logic [rfc_pkg::STAT_W-1:0]       out_status;
  rfc_pkg::coord_t                  out_xf;
  rfc_pkg::coord_t                  out_xe;
  logic [rfc_pkg::ROW_W-1:0]        out_yf;
  logic [rfc_pkg::ROW_W-1:0]        out_ye;
  logic [rfc_pkg::PIX_W-1:0]        out_npix;
  logic [rfc_pkg::RGB565_W-1:0]     out_color;
  logic                             out_last;

  logic                             accept;
  logic                             emit_load;
  logic [rfc_pkg::COORD_W:0]        x_reach;
  logic [rfc_pkg::COORD_W:0]        y_reach;
  logic                             off_screen;
  logic                             empty;
  rfc_pkg::area_t                   area;
  rfc_pkg::coord_t                  x1;
  rfc_pkg::coord_t                  y1;
  logic [rfc_pkg::COORD_W:0]        xe_raw;
  logic [rfc_pkg::COORD_W:0]        ye_raw;
  rfc_pkg::coord_t                  xe;
  rfc_pkg::coord_t                  ye;
  rfc_pkg::area_t                   span;
  rfc_pkg::area_t                   grab;
  rfc_pkg::area_t                   left;
  logic                             last_now;

  rfc_pkg::div_req_t                div_req;
  rfc_pkg::div_rsp_t                div_rsp;

  rfc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign emit_load = (state == S_EMIT) && (!out_valid || res.ready);

  // request checks
  always_comb begin
    x_reach    = {1'b0, x0} + {1'b0, w};
    y_reach    = {1'b0, y0} + {1'b0, h};
    off_screen = (x_reach > (rfc_pkg::COORD_W + 1)'(rfc_pkg::SCREEN_WIDTH))
              || (y_reach > (rfc_pkg::COORD_W + 1)'(rfc_pkg::SCREEN_HEIGHT));
    empty      = (w == '0) || (h == '0);
    area       = rfc_pkg::area_t'(w) * rfc_pkg::area_t'(h);
  end

  // chunk window and size
  always_comb begin
    x1     = x0 + cx;
    y1     = y0 + ry;
    xe_raw = {1'b0, x1} + {1'b0, w} - (rfc_pkg::COORD_W + 1)'(1);
    ye_raw = {1'b0, y1} + {1'b0, h} - (rfc_pkg::COORD_W + 1)'(1);
    xe     = (xe_raw > (rfc_pkg::COORD_W + 1)'(rfc_pkg::SCREEN_WIDTH - 1))
           ? rfc_pkg::COORD_W'(rfc_pkg::SCREEN_WIDTH - 1) : xe_raw[rfc_pkg::COORD_W-1:0];
    ye     = (ye_raw > (rfc_pkg::COORD_W + 1)'(rfc_pkg::SCREEN_HEIGHT - 1))
           ? rfc_pkg::COORD_W'(rfc_pkg::SCREEN_HEIGHT - 1) : ye_raw[rfc_pkg::COORD_W-1:0];
    span   = (cx != '0) ? rfc_pkg::area_t'(w - cx) : rem;
    grab   = (span > rfc_pkg::area_t'(rfc_pkg::CHUNK_PIXELS))
           ? rfc_pkg::area_t'(rfc_pkg::CHUNK_PIXELS) : span;
    left   = rem - grab;
    last_now = (left == '0) || (k == rfc_pkg::K_W'(rfc_pkg::MAX_RESULTS - 1));
  end

  always_comb begin
    div_req.start    = (state == S_PLAN) && (cx == '0);
    div_req.dividend = rfc_pkg::NPIX_W'(grab);
    div_req.divisor  = w;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_CHECK;
      S_CHECK: state_next = (off_screen || empty) ? S_EMIT : S_PLAN;
      S_PLAN:  state_next = (cx == '0) ? S_DIV : S_EMIT;
      S_DIV:   if (div_rsp.done) state_next = S_EMIT;
      S_EMIT:  if (emit_load) state_next = stg_last ? S_IDLE : S_PLAN;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col <= rfc_pkg::pack565(req.color_rgb888);
      x0  <= req.rect_x;
      w   <= req.rect_width;
      y0  <= req.rect_y;
      h   <= req.rect_height;
    end
    case (state)
      S_CHECK: begin
        rem        <= area;
        cx         <= '0;
        ry         <= '0;
        k          <= '0;
        stg_status <= off_screen ? rfc_pkg::ST_REJECT : rfc_pkg::ST_EMPTY;
        stg_xf     <= '0;
        stg_xe     <= '0;
        stg_yf     <= '0;
        stg_ye     <= '0;
        stg_npix   <= '0;
        stg_last   <= 1'b1;
      end
      S_PLAN: begin
        stg_status <= rfc_pkg::ST_CHUNK;
        stg_xf     <= x1;
        stg_xe     <= xe;
        stg_yf     <= rfc_pkg::ROW_W'(y1);
        stg_ye     <= rfc_pkg::ROW_W'(ye);
        stg_npix   <= rfc_pkg::NPIX_W'(grab);
        stg_last   <= last_now;
        rem        <= left;
        if (cx != '0) begin
          cx <= '0;
          ry <= ry + rfc_pkg::COORD_W'(1);
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          cx <= div_rsp.remainder;
          ry <= ry + rfc_pkg::COORD_W'(div_rsp.quot);
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          k <= k + rfc_pkg::K_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (emit_load) begin
      out_status <= stg_status;
      out_xf     <= stg_xf;
      out_xe     <= stg_xe;
      out_yf     <= stg_yf;
      out_ye     <= stg_ye;
      out_npix   <= rfc_pkg::PIX_W'(stg_npix);
      out_color  <= col;
      out_last   <= stg_last;
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.win_x_first  = out_xf;
  assign res.win_x_end    = out_xe;
  assign res.win_y_first  = out_yf;
  assign res.win_y_end    = out_ye;
  assign res.pixel_count  = out_npix;
  assign res.color_rgb565 = out_color;
  assign res.last_chunk   = out_last;

`ifndef SYNTHESIS
  a_special_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status != rfc_pkg::ST_CHUNK) |-> res.last_chunk)
    else $error("rejected or empty beat without last_chunk");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.status == rfc_pkg::ST_CHUNK) |->
      (res.pixel_count != '0) && (res.win_x_first <= res.win_x_end))
    else $error("chunk beat with no pixels or inverted window");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  a_busy_no_request: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLAN) || (state == S_DIV) |-> !req.ready)
    else $error("request taken while a fill is in progress");
`endif

endmodule
